// ===== hw/rtl/ntt_pkg.sv =====
package ntt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;

  // request codes
  localparam logic [1:0] REQ_OUTBOUND = 2'd0;
  localparam logic [1:0] REQ_INBOUND  = 2'd1;
  localparam logic [1:0] REQ_TICK     = 2'd2;

  // result status codes
  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_OUTER_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT       = 2'd1;
  localparam logic [1:0] CFG_PORT_MIN      = 2'd2;
  localparam logic [1:0] CFG_PORT_MAX      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_PORT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
    logic [31:0] tunnel_addr;
    logic [15:0] tunnel_port;
    logic [15:0] outer_port;
  } entry_t;

  // store write strobes
  typedef struct packed {
    logic touch;
    logic evict;
    logic alloc;
  } wr_t;

endpackage

// ===== hw/rtl/nat_translation_table.sv =====
// Port-translation table with timed expiry. Requests are taken one at a time
// and in_stall stays high while one is in work. An outbound request, or an
// inbound one to outer_address, walks the entry memory one entry at a time,
// each in a read and an evaluate state (single read port with registered
// data); an outbound miss with a free slot then checks candidate ports from
// port_min upwards one per cycle. A hit returns as soon as the walk reaches
// its entry. Ticks and unknown requests give no result. The result sits in
// an output register, so the next request may be taken while it waits. Entry
// memory needs no clearing pass: per-entry valid bits are cleared by reset.
module nat_translation_table
  import ntt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_inner_addr,
  input  logic [15:0] in_inner_port,
  input  logic [31:0] in_tunnel_addr,
  input  logic [15:0] in_tunnel_port,
  input  logic [31:0] in_outer_addr,
  input  logic [15:0] in_outer_port,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_out_outer_port,
  output logic [31:0] out_out_inner_addr,
  output logic [15:0] out_out_inner_port,
  output logic [31:0] out_out_tunnel_addr,
  output logic [15:0] out_out_tunnel_port,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [31:0] outer_address_r;
  logic [15:0] timeout_r, port_min_r, port_max_r;

  logic [IW-1:0] rd_idx, wr_idx;
  entry_t        rd_data, wr_data;
  logic [31:0]   rd_touch, wr_touch;
  logic          rd_valid;
  wr_t           wr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_address_r <= '0;
      timeout_r       <= 16'd60;
      port_min_r      <= 16'd10000;
      port_max_r      <= 16'd60000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OUTER_ADDRESS: outer_address_r <= cfg_data;
        CFG_TIMEOUT:       timeout_r       <= cfg_data[15:0];
        CFG_PORT_MIN:      port_min_r      <= cfg_data[15:0];
        CFG_PORT_MAX:      port_max_r      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ntt_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_req_type, .in_inner_addr, .in_inner_port,
    .in_tunnel_addr, .in_tunnel_port, .in_outer_addr, .in_outer_port,
    .outer_address(outer_address_r), .timeout_seconds(timeout_r),
    .port_min(port_min_r), .port_max(port_max_r),
    .out_valid, .out_stall, .out_status, .out_out_outer_port,
    .out_out_inner_addr, .out_out_inner_port, .out_out_tunnel_addr,
    .out_out_tunnel_port,
    .rd_idx, .rd_data, .rd_touch, .rd_valid,
    .wr, .wr_idx, .wr_data, .wr_touch
  );

  ntt_store #(.ENTRIES(ENTRIES)) u_store (
    .clk, .rst_n,
    .rd_idx, .rd_data, .rd_touch, .rd_valid,
    .wr, .wr_idx, .wr_data, .wr_touch
  );

endmodule

// ===== hw/rtl/ntt_store.sv =====
module ntt_store
  import ntt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned IW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_idx,
  output entry_t        rd_data,
  output logic [31:0]   rd_touch,
  output logic          rd_valid,
  input  wr_t           wr,
  input  logic [IW-1:0] wr_idx,
  input  entry_t        wr_data,
  input  logic [31:0]   wr_touch
);

  entry_t             data_mem [ENTRIES];
  logic [31:0]        touch_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  entry_t             rd_data_r;
  logic [31:0]        rd_touch_r;
  logic               rd_valid_r;

  // entry memories, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr.alloc) begin
      data_mem[wr_idx] <= wr_data;
    end
    if (wr.alloc || wr.touch) begin
      touch_mem[wr_idx] <= wr_touch;
    end
    rd_data_r  <= data_mem[rd_idx];
    rd_touch_r <= touch_mem[rd_idx];
  end

  // valid bits in flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.alloc) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (wr.evict) begin
        valid_r[wr_idx] <= 1'b0;
      end
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_touch = rd_touch_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== hw/rtl/ntt_ctrl.sv =====
module ntt_ctrl
  import ntt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned IW      = $clog2(ENTRIES),
  parameter int unsigned KW      = $clog2(ENTRIES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  logic [31:0]   in_inner_addr,
  input  logic [15:0]   in_inner_port,
  input  logic [31:0]   in_tunnel_addr,
  input  logic [15:0]   in_tunnel_port,
  input  logic [31:0]   in_outer_addr,
  input  logic [15:0]   in_outer_port,
  input  logic [31:0]   outer_address,
  input  logic [15:0]   timeout_seconds,
  input  logic [15:0]   port_min,
  input  logic [15:0]   port_max,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [15:0]   out_out_outer_port,
  output logic [31:0]   out_out_inner_addr,
  output logic [15:0]   out_out_inner_port,
  output logic [31:0]   out_out_tunnel_addr,
  output logic [15:0]   out_out_tunnel_port,
  output logic [IW-1:0] rd_idx,
  input  entry_t        rd_data,
  input  logic [31:0]   rd_touch,
  input  logic          rd_valid,
  output wr_t           wr,
  output logic [IW-1:0] wr_idx,
  output entry_t        wr_data,
  output logic [31:0]   wr_touch
);

  state_t           state_r, state_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic             slot_ok_r, slot_ok_nxt;
  logic [ENTRIES:0] bm_r, bm_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             outb_r, outb_nxt;
  entry_t           req_r, req_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  entry_t           res_r, res_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       ost_r, ost_nxt;
  entry_t           ores_r, ores_nxt;

  logic        accept, last, match, evict;
  logic [31:0] age;
  logic [16:0] diff, cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    slot_r    <= slot_nxt;
    slot_ok_r <= slot_ok_nxt;
    bm_r      <= bm_nxt;
    k_r       <= k_nxt;
    outb_r    <= outb_nxt;
    req_r     <= req_nxt;
    res_st_r  <= res_st_nxt;
    res_r     <= res_nxt;
    ost_r     <= ost_nxt;
    ores_r    <= ores_nxt;
  end

  assign accept = in_valid && !in_stall;
  assign last   = (idx_r == IW'(ENTRIES - 1));
  assign age    = now_r - rd_touch;
  assign match  = (rd_data.inner_addr == req_r.inner_addr) &&
                  (rd_data.inner_port == req_r.inner_port) &&
                  (rd_data.tunnel_addr == req_r.tunnel_addr) &&
                  (rd_data.tunnel_port == req_r.tunnel_port);
  assign evict  = rd_valid && !match && (age > {16'd0, timeout_seconds});
  assign diff   = {1'b0, rd_data.outer_port} - {1'b0, port_min};
  assign cand   = {1'b0, port_min} + 17'(k_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    slot_nxt    = slot_r;
    slot_ok_nxt = slot_ok_r;
    bm_nxt      = bm_r;
    k_nxt       = k_r;
    outb_nxt    = outb_r;
    req_nxt     = req_r;
    now_nxt     = now_r;
    res_st_nxt  = res_st_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r;
    ost_nxt     = ost_r;
    ores_nxt    = ores_r;
    wr          = '0;
    wr_idx      = idx_r;
    wr_data     = req_r;
    wr_data.outer_port = cand[15:0];

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt.inner_addr  = in_inner_addr;
          req_nxt.inner_port  = in_inner_port;
          req_nxt.tunnel_addr = in_tunnel_addr;
          req_nxt.tunnel_port = in_tunnel_port;
          req_nxt.outer_port  = in_outer_port;
          idx_nxt     = '0;
          slot_ok_nxt = 1'b0;
          bm_nxt      = '0;
          k_nxt       = '0;
          res_nxt     = '0;
          priority if (in_req_type == REQ_OUTBOUND) begin
            outb_nxt  = 1'b1;
            state_nxt = S_READ;
          end else if (in_req_type == REQ_INBOUND) begin
            outb_nxt = 1'b0;
            if (in_outer_addr == outer_address) begin
              state_nxt = S_READ;
            end else begin
              res_st_nxt = ST_MISS;
              state_nxt  = S_DONE;
            end
          end else if (in_req_type == REQ_TICK) begin
            now_nxt = now_r + 32'd1;
          end else begin
            // unknown request: dropped
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_READ;
        if (outb_r) begin
          if (rd_valid && match) begin
            wr.touch   = 1'b1;
            res_st_nxt = ST_HIT;
            res_nxt    = rd_data;
            state_nxt  = S_DONE;
          end else begin
            wr.evict = evict;
            if ((!rd_valid || evict) && !slot_ok_r) begin
              slot_nxt    = idx_r;
              slot_ok_nxt = 1'b1;
            end
            // mark ports just above port_min that stay in use
            if (rd_valid && !evict && !diff[16] &&
                diff[15:0] <= 16'(ENTRIES)) begin
              bm_nxt[diff[KW-1:0]] = 1'b1;
            end
            if (last) begin
              if (slot_ok_nxt) begin
                state_nxt = S_PORT;
              end else begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end
            end
          end
        end else begin
          if (rd_valid && rd_data.outer_port == req_r.outer_port &&
              age < {16'd0, timeout_seconds}) begin
            wr.touch   = 1'b1;
            res_st_nxt = ST_HIT;
            res_nxt    = rd_data;
            state_nxt  = S_DONE;
          end else if (last) begin
            res_st_nxt = ST_MISS;
            state_nxt  = S_DONE;
          end
        end
      end
      S_PORT: begin
        // lowest free port, one candidate a cycle
        if (bm_r[k_r]) begin
          k_nxt = k_r + KW'(1);
        end else if (cand > {1'b0, port_max}) begin
          res_st_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          wr.alloc   = 1'b1;
          wr_idx     = slot_r;
          res_st_nxt = ST_CREATED;
          res_nxt    = wr_data;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          ores_nxt  = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall            = (state_r != S_IDLE);
  assign rd_idx              = idx_r;
  assign wr_touch            = now_r;
  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_out_outer_port  = ores_r.outer_port;
  assign out_out_inner_addr  = ores_r.inner_addr;
  assign out_out_inner_port  = ores_r.inner_port;
  assign out_out_tunnel_addr = ores_r.tunnel_addr;
  assign out_out_tunnel_port = ores_r.tunnel_port;

endmodule

// ===== tb/tb.sv =====
module tb;
  import ntt_pkg::*;

  localparam int NSLOT     = ENTRIES_DEF;
  localparam int POOL      = 80;
  localparam int MAX_CYC   = 1200000;
  localparam int SETTLE    = 4 * NSLOT + 80;
  localparam int HOLD_CYCS = 400;

  typedef struct {
    logic [1:0]  req_type;
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
    logic [31:0] tunnel_addr;
    logic [15:0] tunnel_port;
    logic [31:0] outer_addr;
    logic [15:0] outer_port;
    bit          drain;
  } req_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] outer_port;
    logic [31:0] inner_addr;
    logic [15:0] inner_port;
    logic [31:0] tunnel_addr;
    logic [15:0] tunnel_port;
  } resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [31:0] in_inner_addr;
  logic [15:0] in_inner_port;
  logic [31:0] in_tunnel_addr;
  logic [15:0] in_tunnel_port;
  logic [31:0] in_outer_addr;
  logic [15:0] in_outer_port;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_out_outer_port;
  logic [31:0] out_out_inner_addr;
  logic [15:0] out_out_inner_port;
  logic [31:0] out_out_tunnel_addr;
  logic [15:0] out_out_tunnel_port;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  nat_translation_table u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_inner_addr       (in_inner_addr),
    .in_inner_port       (in_inner_port),
    .in_tunnel_addr      (in_tunnel_addr),
    .in_tunnel_port      (in_tunnel_port),
    .in_outer_addr       (in_outer_addr),
    .in_outer_port       (in_outer_port),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_out_outer_port  (out_out_outer_port),
    .out_out_inner_addr  (out_out_inner_addr),
    .out_out_inner_port  (out_out_inner_port),
    .out_out_tunnel_addr (out_out_tunnel_addr),
    .out_out_tunnel_port (out_out_tunnel_port),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // shadow of the translation table
  logic [31:0] m_outer_address;
  logic [15:0] m_timeout;
  logic [15:0] m_port_min;
  logic [15:0] m_port_max;
  bit          m_valid [NSLOT];
  logic [31:0] m_inner_addr [NSLOT];
  logic [15:0] m_inner_port [NSLOT];
  logic [31:0] m_tunnel_addr [NSLOT];
  logic [15:0] m_tunnel_port [NSLOT];
  logic [15:0] m_outer_port [NSLOT];
  logic [31:0] m_touch [NSLOT];
  logic [31:0] m_now;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  req_t  cur_req;

  logic [31:0] pool_ia [POOL];
  logic [15:0] pool_ip [POOL];
  logic [31:0] pool_ta [POOL];
  logic [15:0] pool_tp [POOL];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_req;
  int  hold_cnt;
  int  cycles;
  int  errors;
  int  n_accepted;
  int  n_status [4];

  function automatic bit port_taken(int p);
    for (int i = 0; i < NSLOT; i++)
      if (m_valid[i] && m_outer_port[i] == p[15:0]) return 1;
    return 0;
  endfunction

  function automatic resp_t slot_resp(logic [1:0] st, int i);
    resp_t r;
    r = '{st, 16'd0, 32'd0, 16'd0, 32'd0, 16'd0};
    if (i >= 0) begin
      r.outer_port  = m_outer_port[i];
      r.inner_addr  = m_inner_addr[i];
      r.inner_port  = m_inner_port[i];
      r.tunnel_addr = m_tunnel_addr[i];
      r.tunnel_port = m_tunnel_port[i];
    end
    return r;
  endfunction

  // advance the shadow table by one accepted transfer and queue its result, if it has one
  task automatic translate(input req_t q);
    int          slot;
    int          p;
    logic [31:0] age;
    begin
      slot = -1;
      case (q.req_type)
        REQ_OUTBOUND: begin
          for (int i = 0; i < NSLOT; i++) begin
            if (m_valid[i] && slot < 0) begin
              if (m_inner_addr[i] == q.inner_addr && m_inner_port[i] == q.inner_port &&
                  m_tunnel_addr[i] == q.tunnel_addr &&
                  m_tunnel_port[i] == q.tunnel_port) begin
                m_touch[i] = m_now;
                slot = i;
              end else begin
                age = m_now - m_touch[i];
                if (age > {16'd0, m_timeout}) m_valid[i] = 0;
              end
            end
          end
          if (slot >= 0) begin
            expected_resps.push_back(slot_resp(ST_HIT, slot));
          end else begin
            for (int i = NSLOT - 1; i >= 0; i--)
              if (!m_valid[i]) slot = i;
            p = int'(m_port_min);
            while (p <= int'(m_port_max) && port_taken(p)) p++;
            if (slot < 0 || p > int'(m_port_max)) begin
              expected_resps.push_back(slot_resp(ST_FULL, -1));
            end else begin
              m_valid[slot]       = 1;
              m_inner_addr[slot]  = q.inner_addr;
              m_inner_port[slot]  = q.inner_port;
              m_tunnel_addr[slot] = q.tunnel_addr;
              m_tunnel_port[slot] = q.tunnel_port;
              m_outer_port[slot]  = p[15:0];
              m_touch[slot]       = m_now;
              expected_resps.push_back(slot_resp(ST_CREATED, slot));
            end
          end
        end
        REQ_INBOUND: begin
          if (q.outer_addr == m_outer_address) begin
            for (int i = 0; i < NSLOT; i++) begin
              age = m_now - m_touch[i];
              if (slot < 0 && m_valid[i] && m_outer_port[i] == q.outer_port &&
                  age < {16'd0, m_timeout}) begin
                m_touch[i] = m_now;
                slot = i;
              end
            end
          end
          expected_resps.push_back(slot >= 0 ? slot_resp(ST_HIT, slot)
                                             : slot_resp(ST_MISS, -1));
        end
        REQ_TICK: m_now = m_now + 32'd1;
        default: ;
      endcase
    end
  endtask

  // clock and run limit
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("%0t: run limit reached, %0d results still awaited", $time,
               expected_resps.size());
      $display("nat_translation_table test failed");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        translate(cur_req);
        n_accepted++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (pending_reqs.size() > 0 && pending_reqs[0].drain) begin
        in_valid <= 1'b0;
        if (expected_resps.size() == 0) void'(pending_reqs.pop_front());
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        in_valid       <= 1'b1;
        in_req_type    <= cur_req.req_type;
        in_inner_addr  <= cur_req.inner_addr;
        in_inner_port  <= cur_req.inner_port;
        in_tunnel_addr <= cur_req.tunnel_addr;
        in_tunnel_port <= cur_req.tunnel_port;
        in_outer_addr  <= cur_req.outer_addr;
        in_outer_port  <= cur_req.outer_port;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    resp_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result, status %0d port %0d", $time, out_status,
                   out_out_outer_port);
          errors++;
        end else begin
          e = expected_resps.pop_front();
          n_status[e.status]++;
          if (out_status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_out_outer_port !== e.outer_port) begin
            $display("%0t: outer_port exp %0d got %0d", $time, e.outer_port,
                     out_out_outer_port);
            errors++;
          end
          if (out_out_inner_addr !== e.inner_addr) begin
            $display("%0t: inner_addr exp %h got %h", $time, e.inner_addr,
                     out_out_inner_addr);
            errors++;
          end
          if (out_out_inner_port !== e.inner_port) begin
            $display("%0t: inner_port exp %0d got %0d", $time, e.inner_port,
                     out_out_inner_port);
            errors++;
          end
          if (out_out_tunnel_addr !== e.tunnel_addr) begin
            $display("%0t: tunnel_addr exp %h got %h", $time, e.tunnel_addr,
                     out_out_tunnel_addr);
            errors++;
          end
          if (out_out_tunnel_port !== e.tunnel_port) begin
            $display("%0t: tunnel_port exp %0d got %0d", $time, e.tunnel_port,
                     out_out_tunnel_port);
            errors++;
          end
        end
      end
      // long hold-off on request, else random stalls
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= HOLD_CYCS;
        hold_req <= 1'b0;
        out_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic req_t mk(logic [1:0] rt, logic [31:0] ia, logic [15:0] ip,
                              logic [31:0] ta, logic [15:0] tp, logic [31:0] oa,
                              logic [15:0] op);
    req_t q;
    q = '{rt, ia, ip, ta, tp, oa, op, 1'b0};
    return q;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      case (idx)
        CFG_OUTER_ADDRESS: m_outer_address = val;
        CFG_TIMEOUT:       m_timeout       = val[15:0];
        CFG_PORT_MIN:      m_port_min      = val[15:0];
        CFG_PORT_MAX:      m_port_max      = val[15:0];
        default: ;
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // let the table go quiet before touching the registers
  task automatic wait_quiet();
    begin
      while (pending_reqs.size() > 0 || in_valid || expected_resps.size() > 0)
        @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end
  endtask

  task automatic new_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_ia[i] = $urandom;
      pool_ip[i] = 16'($urandom);
      pool_ta[i] = $urandom;
      pool_tp[i] = 16'($urandom);
    end
  endtask

  task automatic push_drain();
    req_t q;
    begin
      q = mk(REQ_TICK, 0, 0, 0, 0, 0, 0);
      q.drain = 1'b1;
      pending_reqs.push_back(q);
    end
  endtask

  // mostly well-formed traffic over a tuple pool, some noise
  task automatic random_phase(input int n);
    req_t q;
    int   k;
    int   sel;
    begin
      for (int j = 0; j < n; j++) begin
        while (pending_reqs.size() > 2) @(posedge clk);
        sel = $urandom_range(99);
        k   = $urandom_range(POOL - 1);
        q   = mk(2'($urandom_range(3)), $urandom, 16'($urandom), $urandom,
                 16'($urandom), $urandom, 16'($urandom));
        if (sel < 45) begin
          q = mk(REQ_OUTBOUND, pool_ia[k], pool_ip[k], pool_ta[k], pool_tp[k],
                 $urandom, 16'($urandom));
        end else if (sel < 67) begin
          k = $urandom_range(NSLOT - 1);
          q.req_type   = REQ_INBOUND;
          q.outer_addr = ($urandom_range(9) != 0) ? m_outer_address : $urandom;
          q.outer_port = m_valid[k] ? m_outer_port[k]
                                    : 16'(m_port_min + $urandom_range(3));
        end else if (sel < 82) begin
          q.req_type = REQ_TICK;
        end
        pending_reqs.push_back(q);
        if (j == n / 2) push_drain();
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = '0;
    in_inner_addr = '0;
    in_inner_port = '0;
    in_tunnel_addr = '0;
    in_tunnel_port = '0;
    in_outer_addr = '0;
    in_outer_port = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    n_accepted = 0;
    n_status = '{0, 0, 0, 0};
    hold_req = 1'b0;
    hold_cnt = 0;
    send_idle_pct = 10;
    recv_idle_pct = 58;
    m_outer_address = 32'd0;
    m_timeout = 16'd60;
    m_port_min = 16'd10000;
    m_port_max = 16'd60000;
    m_now = 32'd0;
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 0;
      m_inner_addr[i] = '0;
      m_inner_port[i] = '0;
      m_tunnel_addr[i] = '0;
      m_tunnel_port[i] = '0;
      m_outer_port[i] = '0;
      m_touch[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, hit, refresh, misses, tick, unknown request
    pending_reqs.push_back(mk(REQ_OUTBOUND, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_OUTBOUND, '1, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_OUTBOUND, 0, 0, 0, 0, '1, '1));
    pending_reqs.push_back(mk(REQ_INBOUND, '1, '1, '1, '1, 0, 16'd10001));
    pending_reqs.push_back(mk(REQ_INBOUND, 0, 0, 0, 0, '1, 16'd10000));
    pending_reqs.push_back(mk(REQ_INBOUND, 0, 0, 0, 0, 0, '1));
    pending_reqs.push_back(mk(2'd3, '1, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_TICK, '1, '1, '1, '1, '1, '1));
    pending_reqs.push_back(mk(REQ_OUTBOUND, 0, 0, 0, 16'd1, 0, 0));
    pending_reqs.push_back(mk(REQ_INBOUND, 0, 0, 0, 0, 0, 16'd10000));
    pending_reqs.push_back(mk(REQ_OUTBOUND, '1, '1, '1, '1, 0, 0));
    wait_quiet();

    // phase one: short timeout, narrow port range, receiver held off early
    cfg_write(CFG_OUTER_ADDRESS, $urandom);
    cfg_write(CFG_TIMEOUT, 32'd5);
    cfg_write(CFG_PORT_MIN, 32'd100);
    cfg_write(CFG_PORT_MAX, 32'd140);
    new_pool();
    hold_req = 1'b1;
    random_phase(550);
    wait_quiet();

    // phase two: port range from 1 up, longest timeout, table fills up
    send_idle_pct = 58;
    recv_idle_pct = 10;
    cfg_write(CFG_OUTER_ADDRESS, 32'hFFFF_FFFF);
    cfg_write(CFG_TIMEOUT, 32'd65535);
    cfg_write(CFG_PORT_MIN, 32'd1);
    cfg_write(CFG_PORT_MAX, 32'd65535);
    new_pool();
    random_phase(550);
    wait_quiet();

    // phase three: single top port, timeout of one tick, then an empty range
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(CFG_OUTER_ADDRESS, 32'd0);
    cfg_write(CFG_TIMEOUT, 32'd1);
    cfg_write(CFG_PORT_MIN, 32'd65535);
    new_pool();
    random_phase(300);
    wait_quiet();
    cfg_write(CFG_TIMEOUT, 32'd3);
    cfg_write(CFG_PORT_MIN, 32'd200);
    cfg_write(CFG_PORT_MAX, 32'd100);
    random_phase(250);
    wait_quiet();

    $display("covered %0d requests over five register settings", n_accepted);
    $display("results: %0d hits, %0d created, %0d inbound misses, %0d full",
             n_status[ST_HIT], n_status[ST_CREATED], n_status[ST_MISS],
             n_status[ST_FULL]);
    if (errors == 0) begin
      $display("nat_translation_table test passed");
    end else begin
      $display("nat_translation_table test failed");
    end
    $finish;
  end

endmodule
